@@ hw/rtl/rwcs_pkg.sv @@
// Shared types and constants for the ray/wall column span unit.
package rwcs_pkg;

    localparam int FRAME_HEIGHT_DEF = 600;
    localparam int VAL_W            = 16;
    localparam int ROW_W            = 10;
    localparam int DIV_DW           = 32;
    localparam int QUOT_W           = 16;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CAMERA_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAN_HALF_FOV  = 1'd1;

    localparam logic signed [VAL_W-1:0] CAMERA_HEIGHT_RST = 16'sd154;
    localparam logic [VAL_W-1:0]        TAN_HALF_FOV_RST  = 16'd148;

    localparam logic signed [VAL_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] ray_x;
        logic signed [15:0] wall_ax;
        logic signed [15:0] wall_ay;
        logic signed [15:0] wall_bx;
        logic signed [15:0] wall_by;
        logic signed [15:0] floor_height;
        logic signed [15:0] top_height;
        logic [15:0]        wall_length;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [15:0]        wall_fraction;
        logic signed [15:0] hit_depth;
        logic signed [15:0] span_bottom;
        logic signed [15:0] span_top;
        logic [9:0]         draw_bottom;
        logic [9:0]         draw_top;
        logic [15:0]        tex_u;
    } out_item_t;

    // Side data riding along the intersection divider.
    typedef struct packed {
        logic               hit;
        logic               sy_neg;
        logic signed [15:0] ay;
        logic signed [15:0] floor_h;
        logic signed [15:0] top_h;
    } dva_side_t;

    typedef struct packed {
        logic dh_pos;
        logic dh_neg;
        logic neg;
        logic ovf;
    } row_flag_t;

    // Side data riding along the projection divider.
    typedef struct packed {
        logic               hit;
        logic [15:0]        frac;
        logic signed [15:0] depth;
        logic [15:0]        tex;
        logic               dt_zero;
        row_flag_t          bot;
        row_flag_t          top;
    } dvb_side_t;

endpackage

@@ hw/rtl/rwcs_if.sv @@
// Valid/ready channel interfaces for ray items and span results.
interface rwcs_in_if
    import rwcs_pkg::*;
();
    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rwcs_out_if
    import rwcs_pkg::*;
();
    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/rwcs_div_pipe.sv @@
// Pipelined restoring divider: one quotient bit per stage, lanes share a divisor.
module rwcs_div_pipe
    import rwcs_pkg::*;
#(
    parameter int LANES = 1,
    parameter int DW    = DIV_DW,
    parameter int QW    = QUOT_W,
    parameter int SW    = 1
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic [DW-1:0]                  divisor,
    input  logic [LANES-1:0][DW-1:0]       rem_in,
    input  logic [LANES-1:0][QW-1:0]       low_in,
    input  logic [SW-1:0]                  side_in,
    output logic [LANES-1:0][QW-1:0]       quot,
    output logic [SW-1:0]                  side_out
);

    logic [DW-1:0]              div_reg  [QW];
    logic [LANES-1:0][DW-1:0]   rem_reg  [QW];
    logic [LANES-1:0][QW-1:0]   low_reg  [QW];
    logic [LANES-1:0][QW-1:0]   q_reg    [QW];
    logic [SW-1:0]              side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [DW-1:0]            div_src;
        logic [LANES-1:0][DW-1:0] rem_src;
        logic [LANES-1:0][QW-1:0] low_src;
        logic [LANES-1:0][QW-1:0] q_src;
        logic [SW-1:0]            side_src;
        logic [LANES-1:0][DW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] low_next;
        logic [LANES-1:0][QW-1:0] q_next;

        if (k == 0) begin : g_first
            assign div_src  = divisor;
            assign rem_src  = rem_in;
            assign low_src  = low_in;
            assign q_src    = '0;
            assign side_src = side_in;
        end else begin : g_rest
            assign div_src  = div_reg[k-1];
            assign rem_src  = rem_reg[k-1];
            assign low_src  = low_reg[k-1];
            assign q_src    = q_reg[k-1];
            assign side_src = side_reg[k-1];
        end

        always_comb
        begin
            logic [DW:0] trial;
            logic        qbit;
            for (int l = 0; l < LANES; l++)
            begin
                trial = {rem_src[l], low_src[l][QW-1]};
                qbit  = (trial >= {1'b0, div_src});
                if (qbit)
                begin
                    trial = trial - {1'b0, div_src};
                end
                rem_next[l] = trial[DW-1:0];
                low_next[l] = {low_src[l][QW-2:0], 1'b0};
                q_next[l]   = {q_src[l][QW-2:0], qbit};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                div_reg[k]  <= div_src;
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_next;
                q_reg[k]    <= q_next;
                side_reg[k] <= side_src;
            end
        end
    end

    assign quot     = q_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

@@ hw/rtl/rwcs_out_buf.sv @@
// Two-entry output buffer that decouples the pipeline from the result sink.
module rwcs_out_buf
    import rwcs_pkg::*;
#(
    parameter int W = $bits(out_item_t)
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         advance,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] dout
);

    logic [1:0]   cnt_reg, cnt_next;
    logic [W-1:0] e0_reg, e1_reg;
    logic         pop;
    logic         load_e0;

    assign pop       = out_valid && out_ready;
    assign out_valid = (cnt_reg != 2'd0);
    assign advance   = (cnt_reg != 2'd2) || out_ready;
    assign dout      = e0_reg;
    // Incoming beat lands in the head slot when the buffer is empty, or holds one beat that is leaving.
    assign load_e0   = push && ((cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop));

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_e0)
        begin
            e0_reg <= din;
        end
        else if (pop)
        begin
            e0_reg <= e1_reg;
        end
        if (push && !load_e0)
        begin
            e1_reg <= din;
        end
    end

endmodule

@@ hw/rtl/ray_wall_column_span_unit.sv @@
// Top level: ray/wall intersection, depth, row projection and span clamping.
//
//  channel   | dir | handshake       | beat
//  ----------+-----+-----------------+-----------------------------------------
//  ray_in    | in  | valid/ready     | one column ray plus one wall segment
//  span_out  | out | valid/ready     | hit flag, fraction, depth, rows, tex u
//  cfg       | in  | cfg_we          | camera_height (0), tan_half_fov (1)
//
// One beat enters per cycle unless the pipeline holds; each passes the pipeline
// registers, then the output buffer. Two 16-stage dividers, one bit per stage:
// the first gives fraction, depth and tex u, the second the two projected rows.
// Reset clears valid bits and the buffer count and loads the config defaults.
// A two-entry output buffer takes results while the sink stalls; the whole
// pipeline holds only when both entries are full and the sink is not ready.
module ray_wall_column_span_unit
    import rwcs_pkg::*;
#(
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rwcs_in_if.sink              ray_in,
    rwcs_out_if.source           span_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_wdata
);

    localparam int PIPE_DEPTH = 7 + 2 * QUOT_W;
    localparam int DIVB_OUT   = PIPE_DEPTH - 1;
    localparam logic signed [11:0] FH_S    = 12'(FRAME_HEIGHT);
    localparam logic signed [15:0] FH_HALF = 16'(FRAME_HEIGHT / 2);
    localparam logic signed [15:0] FH_ROW  = 16'(FRAME_HEIGHT);

    // Config registers, to be written by the user only while idle; the block does not enforce it.
    logic signed [15:0] cam_reg;
    logic [15:0]        tan_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg <= CAMERA_HEIGHT_RST;
            tan_reg <= TAN_HALF_FOV_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CAMERA_HEIGHT: cam_reg <= cfg_wdata;
                REG_TAN_HALF_FOV:  tan_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // Global advance: every stage moves when the output buffer has room.
    logic                  adv;
    logic [PIPE_DEPTH-1:0] v_reg;

    assign ray_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[PIPE_DEPTH-2:0], ray_in.valid};
        end
    end

    // Stage 0: segment direction and the two cross-product multiplies.
    logic signed [16:0] sx_w, sy_w;
    logic signed [32:0] s0_rs_reg;
    logic signed [31:0] s0_ayrx_reg;
    logic signed [16:0] s0_sx_reg, s0_sy_reg;
    logic signed [15:0] s0_ax_reg, s0_ay_reg, s0_fl_reg, s0_tp_reg;
    logic [15:0]        s0_len_reg;

    assign sx_w = 17'(ray_in.data.wall_bx) - 17'(ray_in.data.wall_ax);
    assign sy_w = 17'(ray_in.data.wall_by) - 17'(ray_in.data.wall_ay);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_rs_reg   <= 33'(ray_in.data.ray_x) * 33'(sy_w);
            s0_ayrx_reg <= 32'(ray_in.data.wall_ay) * 32'(ray_in.data.ray_x);
            s0_sx_reg   <= sx_w;
            s0_sy_reg   <= sy_w;
            s0_ax_reg   <= ray_in.data.wall_ax;
            s0_ay_reg   <= ray_in.data.wall_ay;
            s0_fl_reg   <= ray_in.data.floor_height;
            s0_tp_reg   <= ray_in.data.top_height;
            s0_len_reg  <= ray_in.data.wall_length;
        end
    end

    // Stage 1: denominator and numerator, sign-normalize, strict-inside test.
    logic signed [33:0] den_w, num_w, den_n, num_n;
    logic               hit_w;
    logic               s1_hit_reg;
    logic [31:0]        s1_den_reg, s1_num_reg;
    logic signed [16:0] s1_sy_reg;
    logic signed [15:0] s1_ay_reg, s1_fl_reg, s1_tp_reg;
    logic [15:0]        s1_len_reg;

    always_comb
    begin
        den_w = 34'(s0_rs_reg) - (34'(s0_sx_reg) <<< 8);
        num_w = (34'(s0_ax_reg) <<< 8) - 34'(s0_ayrx_reg);
        den_n = den_w;
        num_n = num_w;
        if (den_w < 0)
        begin
            den_n = -den_w;
            num_n = -num_w;
        end
        hit_w = (den_w != 0) && (num_n > 0) && (num_n < den_n);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_hit_reg <= hit_w;
            s1_den_reg <= den_n[31:0];
            s1_num_reg <= num_n[31:0];
            s1_sy_reg  <= s0_sy_reg;
            s1_ay_reg  <= s0_ay_reg;
            s1_fl_reg  <= s0_fl_reg;
            s1_tp_reg  <= s0_tp_reg;
            s1_len_reg <= s0_len_reg;
        end
    end

    // Stage 2: dividends for fraction, depth offset and tex u.
    logic [16:0]        sy_abs_w;
    logic [31:0]        s2_div_reg;
    logic [47:0]        s2_frac_reg, s2_dep_reg, s2_tex_reg;
    dva_side_t          s2_side_reg;

    assign sy_abs_w = s1_sy_reg[16] ? 17'(-s1_sy_reg) : 17'(s1_sy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_div_reg          <= s1_den_reg;
            s2_frac_reg         <= {s1_num_reg, 16'd0};
            s2_dep_reg          <= 48'(sy_abs_w[15:0]) * 48'(s1_num_reg);
            s2_tex_reg          <= 48'(s1_len_reg) * 48'(s1_num_reg);
            s2_side_reg.hit     <= s1_hit_reg;
            s2_side_reg.sy_neg  <= s1_sy_reg[16];
            s2_side_reg.ay      <= s1_ay_reg;
            s2_side_reg.floor_h <= s1_fl_reg;
            s2_side_reg.top_h   <= s1_tp_reg;
        end
    end

    // Intersection divider: quotients known to fit 16 bits on a hit.
    logic [2:0][QUOT_W-1:0] qa_w;
    dva_side_t              da_side_w;
    logic [$bits(dva_side_t)-1:0] da_side_bits;

    rwcs_div_pipe #(
        .LANES (3),
        .DW    (DIV_DW),
        .QW    (QUOT_W),
        .SW    ($bits(dva_side_t))
    ) u_div_a (
        .clk      (clk),
        .en       (adv),
        .divisor  (s2_div_reg),
        .rem_in   ({s2_tex_reg[47:16], s2_dep_reg[47:16], s2_frac_reg[47:16]}),
        .low_in   ({s2_tex_reg[15:0], s2_dep_reg[15:0], s2_frac_reg[15:0]}),
        .side_in  (s2_side_reg),
        .quot     (qa_w),
        .side_out (da_side_bits)
    );

    assign da_side_w = dva_side_t'(da_side_bits);

    // Stage E: saturated depth and height differences.
    logic signed [17:0] dsum_w;
    logic signed [15:0] depth_w;
    logic               se_hit_reg;
    logic [15:0]        se_frac_reg, se_tex_reg;
    logic signed [15:0] se_depth_reg;
    logic signed [16:0] se_dhb_reg, se_dht_reg;

    always_comb
    begin
        dsum_w = 18'(da_side_w.ay) +
                 (da_side_w.sy_neg ? -18'(qa_w[1]) : 18'(qa_w[1]));
        if (dsum_w > 18'(SAT_MAX))
        begin
            depth_w = SAT_MAX;
        end
        else if (dsum_w < 18'(SAT_MIN))
        begin
            depth_w = SAT_MIN;
        end
        else
        begin
            depth_w = dsum_w[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            se_hit_reg   <= da_side_w.hit;
            se_frac_reg  <= qa_w[0];
            se_tex_reg   <= qa_w[2];
            se_depth_reg <= depth_w;
            se_dhb_reg   <= 17'(da_side_w.floor_h) - 17'(cam_reg);
            se_dht_reg   <= 17'(da_side_w.top_h) - 17'(cam_reg);
        end
    end

    // Stage F: half height dt = depth * tan (Q24.8).
    logic signed [32:0] sf_dt_reg;
    logic               sf_hit_reg;
    logic [15:0]        sf_frac_reg, sf_tex_reg;
    logic signed [15:0] sf_depth_reg;
    logic signed [16:0] sf_dhb_reg, sf_dht_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sf_dt_reg    <= 33'(se_depth_reg) * 33'(signed'({1'b0, tan_reg}));
            sf_hit_reg   <= se_hit_reg;
            sf_frac_reg  <= se_frac_reg;
            sf_tex_reg   <= se_tex_reg;
            sf_depth_reg <= se_depth_reg;
            sf_dhb_reg   <= se_dhb_reg;
            sf_dht_reg   <= se_dht_reg;
        end
    end

    // Stage G: row numerators FH*dt + FH*dh*512 and divisor 2*dt.
    logic signed [45:0] sg_nb_reg, sg_nt_reg;
    logic signed [33:0] sg_d_reg;
    logic               sg_dtz_reg;
    logic               sg_hit_reg;
    logic [15:0]        sg_frac_reg, sg_tex_reg;
    logic signed [15:0] sg_depth_reg;
    logic [1:0]         sg_sb_reg, sg_st_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sg_nb_reg    <= 46'(sf_dt_reg) * 46'(FH_S) + (46'(sf_dhb_reg) <<< 9) * 46'(FH_S);
            sg_nt_reg    <= 46'(sf_dt_reg) * 46'(FH_S) + (46'(sf_dht_reg) <<< 9) * 46'(FH_S);
            sg_d_reg     <= 34'(sf_dt_reg) <<< 1;
            sg_dtz_reg   <= (sf_dt_reg == 0);
            sg_hit_reg   <= sf_hit_reg;
            sg_frac_reg  <= sf_frac_reg;
            sg_tex_reg   <= sf_tex_reg;
            sg_depth_reg <= sf_depth_reg;
            sg_sb_reg    <= {sf_dhb_reg > 0, sf_dhb_reg < 0};
            sg_st_reg    <= {sf_dht_reg > 0, sf_dht_reg < 0};
        end
    end

    // Stage H: magnitudes, result sign and overflow for both rows.
    logic [33:0] d_abs_w;
    logic [45:0] nb_abs_w, nt_abs_w;
    logic [31:0] dmag_w;
    logic [47:0] nbmag_w, ntmag_w;
    logic [31:0] sh_div_reg;
    logic [47:0] sh_nb_reg, sh_nt_reg;
    dvb_side_t   sh_side_reg;

    always_comb
    begin
        d_abs_w  = sg_d_reg[33] ? 34'(-sg_d_reg) : 34'(sg_d_reg);
        nb_abs_w = sg_nb_reg[45] ? 46'(-sg_nb_reg) : 46'(sg_nb_reg);
        nt_abs_w = sg_nt_reg[45] ? 46'(-sg_nt_reg) : 46'(sg_nt_reg);
        dmag_w   = d_abs_w[31:0];
        nbmag_w  = 48'(nb_abs_w);
        ntmag_w  = 48'(nt_abs_w);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sh_div_reg         <= dmag_w;
            sh_nb_reg          <= nbmag_w;
            sh_nt_reg          <= ntmag_w;
            sh_side_reg.hit    <= sg_hit_reg;
            sh_side_reg.frac   <= sg_frac_reg;
            sh_side_reg.depth  <= sg_depth_reg;
            sh_side_reg.tex    <= sg_tex_reg;
            sh_side_reg.dt_zero <= sg_dtz_reg;
            sh_side_reg.bot.dh_pos <= sg_sb_reg[1];
            sh_side_reg.bot.dh_neg <= sg_sb_reg[0];
            sh_side_reg.bot.neg    <= sg_nb_reg[45] ^ sg_d_reg[33];
            sh_side_reg.bot.ovf    <= (nbmag_w[47:16] >= dmag_w);
            sh_side_reg.top.dh_pos <= sg_st_reg[1];
            sh_side_reg.top.dh_neg <= sg_st_reg[0];
            sh_side_reg.top.neg    <= sg_nt_reg[45] ^ sg_d_reg[33];
            sh_side_reg.top.ovf    <= (ntmag_w[47:16] >= dmag_w);
        end
    end

    // Projection divider: row magnitudes, overflow flagged ahead of it.
    logic [1:0][QUOT_W-1:0]        qb_w;
    logic [$bits(dvb_side_t)-1:0]  db_side_bits;
    dvb_side_t                     db_side_w;

    rwcs_div_pipe #(
        .LANES (2),
        .DW    (DIV_DW),
        .QW    (QUOT_W),
        .SW    ($bits(dvb_side_t))
    ) u_div_b (
        .clk      (clk),
        .en       (adv),
        .divisor  (sh_div_reg),
        .rem_in   ({sh_nt_reg[47:16], sh_nb_reg[47:16]}),
        .low_in   ({sh_nt_reg[15:0], sh_nb_reg[15:0]}),
        .side_in  (sh_side_reg),
        .quot     (qb_w),
        .side_out (db_side_bits)
    );

    assign db_side_w = dvb_side_t'(db_side_bits);

    // Final row value: zero half height, saturation, then sign.
    function automatic logic signed [15:0] row_value(
        input row_flag_t   f,
        input logic        dtz,
        input logic [15:0] q
    );
        logic signed [15:0] r;
        if (dtz)
        begin
            if (f.dh_pos)
            begin
                r = SAT_MAX;
            end
            else if (f.dh_neg)
            begin
                r = SAT_MIN;
            end
            else
            begin
                r = FH_HALF;
            end
        end
        else if (f.ovf || q[15])
        begin
            r = f.neg ? SAT_MIN : SAT_MAX;
        end
        else
        begin
            r = f.neg ? 16'(-signed'({1'b0, q})) : signed'(q);
        end
        return r;
    endfunction

    function automatic logic [9:0] clamp_row(input logic signed [15:0] r);
        logic [9:0] c;
        if (r < 0)
        begin
            c = '0;
        end
        else if (r > FH_ROW)
        begin
            c = FH_ROW[9:0];
        end
        else
        begin
            c = r[9:0];
        end
        return c;
    endfunction

    out_item_t          res_w;
    logic signed [15:0] bot_w, top_w;

    always_comb
    begin
        bot_w = row_value(db_side_w.bot, db_side_w.dt_zero, qb_w[0]);
        top_w = row_value(db_side_w.top, db_side_w.dt_zero, qb_w[1]);
        res_w = '0;
        if (db_side_w.hit)
        begin
            res_w.hit           = 1'b1;
            res_w.wall_fraction = db_side_w.frac;
            res_w.hit_depth     = db_side_w.depth;
            res_w.span_bottom   = bot_w;
            res_w.span_top      = top_w;
            res_w.draw_bottom   = clamp_row(bot_w);
            res_w.draw_top      = clamp_row(top_w);
            res_w.tex_u         = db_side_w.tex;
        end
    end

    // Output buffer: push the finished beat, drop it once the sink takes it.
    logic [$bits(out_item_t)-1:0] buf_dout;

    rwcs_out_buf #(
        .W ($bits(out_item_t))
    ) u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (adv && v_reg[DIVB_OUT]),
        .din       (res_w),
        .advance   (adv),
        .out_valid (span_out.valid),
        .out_ready (span_out.ready),
        .dout      (buf_dout)
    );

    assign span_out.data = out_item_t'(buf_dout);

endmodule

@@ tb/rwcs_span_checker.sv @@
// Span checker: watches ray and span channels, predicts results and compares them.
module rwcs_span_checker
    import rwcs_pkg::*;
#(
    parameter int FRAME_HEIGHT = FRAME_HEIGHT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rwcs_in_if                   ray_in,
    rwcs_out_if                  span_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [VAL_W-1:0]     cfg_wdata,
    output int                   mismatches,
    output int                   spans_pending
);

    logic signed [15:0] cam_height;
    logic [15:0]        tan_fov;
    out_item_t          span_queue[$];

    function automatic longint sat_word(longint v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic longint clamp_to_frame(longint v);
        if (v < 0)
        begin
            return 0;
        end
        if (v > FRAME_HEIGHT)
        begin
            return FRAME_HEIGHT;
        end
        return v;
    endfunction

    // Row = trunc(FH/2 + FH*dh*256/dt), dt being the Q24.8 half height.
    function automatic longint row_of(longint dh, longint dt);
        longint n;
        longint d;
        if (dt == 0)
        begin
            if (dh > 0)
            begin
                return 32767;
            end
            if (dh < 0)
            begin
                return -32768;
            end
            return FRAME_HEIGHT / 2;
        end
        n = FRAME_HEIGHT * dt + FRAME_HEIGHT * dh * 512;
        d = 2 * dt;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        return sat_word(n / d);
    endfunction

    function automatic out_item_t predict_span(in_item_t it);
        longint    rx;
        longint    ax;
        longint    ay;
        longint    sx;
        longint    sy;
        longint    den;
        longint    num;
        longint    depth;
        longint    dt;
        longint    bot;
        longint    top;
        out_item_t r;
        r   = '0;
        rx  = $signed(it.ray_x);
        ax  = $signed(it.wall_ax);
        ay  = $signed(it.wall_ay);
        sx  = longint'($signed(it.wall_bx)) - ax;
        sy  = longint'($signed(it.wall_by)) - ay;
        den = rx * sy - 256 * sx;
        num = ax * 256 - ay * rx;
        if (den == 0)
        begin
            return r;
        end
        if (den < 0)
        begin
            den = -den;
            num = -num;
        end
        if (num <= 0 || num >= den)
        begin
            return r;
        end
        depth = sat_word(ay + (sy * num) / den);
        dt    = depth * longint'(tan_fov);
        bot   = row_of(longint'($signed(it.floor_height)) - longint'(cam_height), dt);
        top   = row_of(longint'($signed(it.top_height)) - longint'(cam_height), dt);
        r.hit           = 1'b1;
        r.wall_fraction = 16'((num * 65536) / den);
        r.hit_depth     = 16'(depth);
        r.span_bottom   = 16'(bot);
        r.span_top      = 16'(top);
        r.draw_bottom   = 10'(clamp_to_frame(bot));
        r.draw_top      = 10'(clamp_to_frame(top));
        r.tex_u         = 16'((longint'(it.wall_length) * num) / den);
        return r;
    endfunction

    function automatic int field_differs(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    assign spans_pending = span_queue.size();

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        int        bad;
        if (!rst_n)
        begin
            cam_height <= CAMERA_HEIGHT_RST;
            tan_fov    <= TAN_HALF_FOV_RST;
            mismatches <= 0;
            span_queue.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_CAMERA_HEIGHT)
                begin
                    cam_height <= cfg_wdata;
                end
                else if (cfg_index == REG_TAN_HALF_FOV)
                begin
                    tan_fov <= cfg_wdata;
                end
            end
            if (ray_in.valid && ray_in.ready)
            begin
                span_queue.insert(span_queue.size(), predict_span(ray_in.data));
            end
            if (span_out.valid && span_out.ready)
            begin
                got = span_out.data;
                if (span_queue.size() == 0)
                begin
                    $error("span beat with no expectation waiting");
                    mismatches <= mismatches + 1;
                end
                else
                begin
                    want = span_queue.pop_front();
                    bad  = 0;
                    bad += field_differs("hit", want.hit, got.hit);
                    bad += field_differs("wall_fraction", want.wall_fraction,
                                         got.wall_fraction);
                    bad += field_differs("hit_depth", want.hit_depth, got.hit_depth);
                    bad += field_differs("span_bottom", want.span_bottom,
                                         got.span_bottom);
                    bad += field_differs("span_top", want.span_top, got.span_top);
                    bad += field_differs("draw_bottom", want.draw_bottom,
                                         got.draw_bottom);
                    bad += field_differs("draw_top", want.draw_top, got.draw_top);
                    bad += field_differs("tex_u", want.tex_u, got.tex_u);
                    if (bad != 0)
                    begin
                        mismatches <= mismatches + 1;
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_ray_wall_column_span_unit.sv @@
// Testbench top: clock, reset, ray stimulus, span sink, config phases and verdict.
module tb_ray_wall_column_span_unit
    import rwcs_pkg::*;
();

    localparam int  RANDOM_PER_PHASE = 235;
    localparam int  DRAIN_CYCLES     = 60;
    localparam longint CYCLE_LIMIT   = 600000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [VAL_W-1:0]     cfg_wdata;
    int                   mismatches;
    int                   spans_pending;
    longint               cycles = 0;
    bit                   burst_send = 0;
    bit                   burst_take = 0;

    rwcs_in_if  ray_in ();
    rwcs_out_if span_out ();

    ray_wall_column_span_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray_in    (ray_in),
        .span_out  (span_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    rwcs_span_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .ray_in        (ray_in),
        .span_out      (span_out),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .spans_pending (spans_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog: end the run if the pipeline wedges.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic in_item_t make_ray(int rx, int ax, int ay, int bx, int by,
                                          int fl, int tp, int len);
        in_item_t it;
        it.ray_x        = 16'(rx);
        it.wall_ax      = 16'(ax);
        it.wall_ay      = 16'(ay);
        it.wall_bx      = 16'(bx);
        it.wall_by      = 16'(by);
        it.floor_height = 16'(fl);
        it.top_height   = 16'(tp);
        it.wall_length  = 16'(len);
        return it;
    endfunction

    // Offer one beat after a random gap (none in a burst); keep valid high across back-to-back
    // beats so it is never dropped and raised in the same step.
    task automatic send_ray(in_item_t it);
        int gap;
        gap = burst_send ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            ray_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray_in.valid <= 1'b1;
        ray_in.data  <= it;
        @(posedge clk);
        while (!ray_in.ready)
        begin
            @(posedge clk);
        end
    endtask

    // Mostly well-formed crossings: endpoints straddle the ray, so the hit
    // path with real depths and rows gets exercised; the rest is raw noise.
    function automatic in_item_t random_ray(int cam);
        int rx;
        int ay;
        int by;
        int ax;
        int bx;
        int t;
        if ($urandom_range(0, 9) < 3)
        begin
            return in_item_t'({$urandom, $urandom, $urandom, $urandom});
        end
        rx = ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 65535)) - 32768
                                         : int'($urandom_range(0, 1023)) - 512;
        ay = $urandom_range(1, 8192);
        by = $urandom_range(1, 8192);
        if ($urandom_range(0, 9) == 0)
        begin
            ay = -ay;
        end
        ax = (rx * ay) / 256 - int'($urandom_range(1, 4096));
        bx = (rx * by) / 256 + int'($urandom_range(1, 4096));
        if ($urandom_range(0, 1))
        begin
            t  = ax;
            ax = bx;
            bx = t;
        end
        return make_ray(rx, ax, ay, bx, by,
                        cam + int'($urandom_range(0, 4096)) - 2048,
                        cam + int'($urandom_range(0, 4096)) - 2048,
                        $urandom_range(0, 65535));
    endfunction

    // Span sink: random stalls per beat, plus one long hold-off once the run is
    // under way so the output buffer and the whole pipeline back up.
    initial
    begin
        int wait_cycles;
        int taken;
        taken = 0;
        span_out.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = burst_take ? 0 : $urandom_range(0, 3);
            if (taken == 300)
            begin
                wait_cycles = 250;
            end
            if (wait_cycles > 0)
            begin
                span_out.ready <= 1'b0;
                repeat (wait_cycles) @(posedge clk);
            end
            span_out.ready <= 1'b1;
            @(posedge clk);
            while (!span_out.valid)
            begin
                @(posedge clk);
            end
            taken++;
        end
    end

    // Raise the write for one edge; the caller drops cfg_we after the last one.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    // Let every expected span arrive and the pipeline go quiet.
    task automatic drain();
        while (spans_pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int       cams[6];
        int       tans[6];
        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_CAMERA_HEIGHT;
        cfg_wdata      <= '0;
        ray_in.valid   <= 1'b0;
        ray_in.data    <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase zero runs on the reset register values.
        cams = '{154, -32768, 32767, 0, 154, 154};
        tans = '{148, 0, 65535, 256, 148, 148};
        cams[4] = int'($urandom_range(0, 65535)) - 32768;
        tans[5] = $urandom_range(0, 65535);

        // Parallel wall: zero denominator.
        send_ray(make_ray(0, 256, 256, 256, 512, 0, 512, 1024));
        // Plain crossing at the middle.
        send_ray(make_ray(0, -512, 1024, 512, 1024, 0, 512, 1024));
        // Crossing exactly at the first and at the second endpoint: misses.
        send_ray(make_ray(0, 0, 1024, 512, 1024, 0, 512, 1024));
        send_ray(make_ray(0, -512, 1024, 0, 1024, 0, 512, 1024));
        // Wall behind the camera: negative depth.
        send_ray(make_ray(0, -512, -1024, 512, -1024, 0, 512, 1024));
        // Zero depth: rows saturate up, down, or sit at mid frame.
        send_ray(make_ray(0, -256, -256, 256, 256, 0, 512, 1024));
        send_ray(make_ray(0, -256, -256, 256, 256, 154, 154, 1024));
        // Fraction below one LSB of Q0.16.
        send_ray(make_ray(32767, 1, 0, -32768, 32767, 0, 512, 65535));
        // Very shallow hit: rows saturate past both ends.
        send_ray(make_ray(0, -256, 1, 256, 1, 32767, -32768, 65535));
        // Field extremes.
        send_ray(make_ray(-32768, -32768, -32768, -32768, -32768,
                          -32768, -32768, 0));
        send_ray(make_ray(32767, 32767, 32767, 32767, 32767,
                          32767, 32767, 65535));
        send_ray(make_ray(-32768, 32767, 1, -32768, 32767, -32768, 32767, 65535));
        send_ray(make_ray(1, -32768, 256, 32767, 256, 0, 2048, 65535));
        // Span lying wholly off screen below and above.
        send_ray(make_ray(0, -512, 256, 512, 256, -8000, -7000, 300));
        send_ray(make_ray(0, -512, 256, 512, 256, 7000, 8000, 300));

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
            begin
                ray_in.valid <= 1'b0;
                drain();
                write_reg(REG_CAMERA_HEIGHT, VAL_W'(cams[ph]));
                write_reg(REG_TAN_HALF_FOV, VAL_W'(tans[ph]));
                cfg_we <= 1'b0;
            end
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
            begin
                // Alternate idle-free stretches with randomly gapped ones.
                if (n % 40 == 0)
                begin
                    burst_send = ($urandom_range(0, 3) == 0);
                    burst_take = ($urandom_range(0, 3) == 0);
                end
                send_ray(random_ray(cams[ph]));
            end
        end
        ray_in.valid <= 1'b0;
        burst_take = 0;
        drain();

        if (mismatches == 0 && spans_pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rwcs_pkg.sv
hw/rtl/rwcs_if.sv
hw/rtl/rwcs_div_pipe.sv
hw/rtl/rwcs_out_buf.sv
hw/rtl/ray_wall_column_span_unit.sv
tb/rwcs_span_checker.sv
tb/tb_ray_wall_column_span_unit.sv
